// ===== rtl/core/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Fixed heap geometry.
  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned TAG_DEPTH    = HEAP_BYTES / 4;
  localparam int unsigned TAG_AW       = $clog2(TAG_DEPTH);

  localparam logic [12:0] LIVE_MAX = 13'h1FFF;
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;

  // Operation codes. The spare code behaves as a query.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_SPACE   = 3'd1,
    STS_ZERO_SIZE  = 3'd2,
    STS_IGNORED    = 3'd3,
    STS_TABLE_FULL = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TAG,
    S_RD,
    S_CHK,
    S_DEC,
    S_SH_RD,
    S_SH_WR,
    S_FIN,
    S_DONE
  } state_e;

  // One free-table entry.
  typedef struct packed {
    logic [16:0] start;
    logic [15:0] len;
  } entry_t;

  // Saturate an 18-bit length to 16 bits.
  function automatic logic [15:0] sat16(input logic [17:0] x);
    logic [15:0] r;
    r = (x > {2'b00, LEN_MAX}) ? LEN_MAX : x[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/ffha_free_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_free_table
// Free-block table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_free_table #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  ffha_pkg::entry_t  wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output ffha_pkg::entry_t  rdata_o
);

  ffha_pkg::entry_t mem [DEPTH];
  ffha_pkg::entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ffha_tag_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_tag_ram
// Block size tags, indexed by header offset divided by four.
// ----------------------------------------------------------------------------
module ffha_tag_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ffha_pkg::TAG_AW-1:0] waddr_i,
  input  logic [15:0]                 wdata_i,
  input  logic                        re_i,
  input  logic [ffha_pkg::TAG_AW-1:0] raddr_i,
  output logic [15:0]                 rdata_o
);

  logic [15:0] mem [ffha_pkg::TAG_DEPTH];
  logic [15:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with an address-sorted free table and coalescing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | opcode, alloc_size, address
//  out     | output    | out_valid_o / out_stall_i | status .. free_bytes
//  cfg     | input     | cfg_valid_i / cfg_ready_o | heap_size (cfg_data_i)
//
// A query goes straight to the result. An allocate scans the free table one
// entry at a time and a table delete moves the entries one at a time; a free
// adds one tag read and may shift the table the same way. The search and the
// shift together pass over the table once per item.
// Reset empties the table through its entry count; no clearing pass.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits at its end until the output register is free.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned MAX_FREE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [16:0] alloc_size_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] payload_offset_o,
  output logic [12:0] live_blocks_o,
  output logic [16:0] used_bytes_o,
  output logic [16:0] free_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_FREE);
  localparam int unsigned CW = $clog2(MAX_FREE + 1);
  localparam int unsigned SW = $clog2(MAX_FREE * 65547 + 1) + 1;
  localparam logic [CW-1:0] NMAX = CW'(MAX_FREE);
  localparam logic [17:0] HDR = 18'(ffha_pkg::HEADER_BYTES);
  localparam logic [17:0] AMASK = ~18'(ffha_pkg::ALIGN_BYTES - 1);
  localparam logic [17:0] AADD = 18'(ffha_pkg::ALIGN_BYTES - 1);

  ffha_pkg::state_e state_q, state_d;

  logic [16:0] heap_size_q;
  logic [CW-1:0] n_q, n_d, idx_q, idx_d, sidx_q, sidx_d;
  logic [16:0] bump_q, bump_d;
  logic [12:0] live_q, live_d;
  logic [SW-1:0] sum_q, sum_d;
  logic is_alloc_q, is_alloc_d, dir_up_q, dir_up_d;
  logic have_prev_q, have_prev_d, have_cur_q, have_cur_d;
  logic [17:0] asize_q, asize_d;
  logic [15:0] h_q, h_d, size_q, size_d;
  ffha_pkg::entry_t prev_q, prev_d, cur_q, cur_d;
  logic [2:0] status_q, status_d;
  logic [15:0] payload_q, payload_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] ostat_q, ostat_d;
  logic [15:0] opay_q, opay_d;
  logic [12:0] olive_q, olive_d;
  logic [16:0] oused_q, oused_d, ofree_q, ofree_d;

  // Memory controls.
  logic ft_we, ft_re;
  logic [IW-1:0] ft_waddr, ft_raddr;
  ffha_pkg::entry_t ft_wdata, ft_rdata;
  logic tg_we, tg_re;
  logic [ffha_pkg::TAG_AW-1:0] tg_waddr, tg_raddr;
  logic [15:0] tg_wdata, tg_rdata;

  ffha_free_table #(.DEPTH(MAX_FREE), .AW(IW)) u_table (
    .clk_i   (clk_i),
    .we_i    (ft_we),
    .waddr_i (ft_waddr),
    .wdata_i (ft_wdata),
    .re_i    (ft_re),
    .raddr_i (ft_raddr),
    .rdata_o (ft_rdata)
  );

  ffha_tag_ram u_tags (
    .clk_i   (clk_i),
    .we_i    (tg_we),
    .waddr_i (tg_waddr),
    .wdata_i (tg_wdata),
    .re_i    (tg_re),
    .raddr_i (tg_raddr),
    .rdata_o (tg_rdata)
  );

  // Shared decode of the current step.
  logic accept, out_free, zero_size, free_bad, scan_end, fit, below, split;
  logic mnext, mprev, bump_fail, shift_last_dn, room_full;
  logic [16:0] heap_top, used_w, free_w;
  logic [15:0] h_in;
  logic [17:0] asize_in, rem, next_bump, merged_w;
  logic [18:0] bump_need;
  logic [15:0] merged, newprev_both, newprev_only;

  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign heap_top   = (heap_size_q > 17'(ffha_pkg::HEAP_BYTES)) ?
                      17'(ffha_pkg::HEAP_BYTES) : heap_size_q;
  assign zero_size  = (alloc_size_i == 17'd0);
  assign asize_in   = ({1'b0, alloc_size_i} + AADD) & AMASK;
  assign h_in       = address_i - 16'(ffha_pkg::HEADER_BYTES);
  assign free_bad   = (address_i < 16'(ffha_pkg::HEADER_BYTES)) ||
                      ({1'b0, h_in} >= heap_top);
  assign scan_end   = (idx_q == n_q);
  assign fit        = ({2'b00, ft_rdata.len} >= asize_q);
  assign rem        = {2'b00, ft_rdata.len} - asize_q;
  assign split      = (rem >= HDR + 18'(ffha_pkg::ALIGN_BYTES));
  assign below      = (ft_rdata.start < {1'b0, h_q});
  assign next_bump  = ({1'b0, bump_q} + AADD) & AMASK;
  assign bump_need  = {1'b0, next_bump} + {1'b0, HDR} + {1'b0, asize_q};
  assign bump_fail  = (bump_need > {2'b00, heap_top});
  assign mnext      = have_cur_q &&
                      (({2'b00, h_q} + HDR + {2'b00, size_q}) == {1'b0, cur_q.start});
  assign mprev      = have_prev_q &&
                      (({1'b0, prev_q.start} + HDR + {2'b00, prev_q.len}) == {2'b00, h_q});
  assign merged_w   = {2'b00, size_q} + HDR + {2'b00, cur_q.len};
  assign merged     = ffha_pkg::sat16(merged_w);
  assign newprev_both = ffha_pkg::sat16({2'b00, prev_q.len} + HDR + {2'b00, merged});
  assign newprev_only = ffha_pkg::sat16({2'b00, prev_q.len} + HDR + {2'b00, size_q});
  assign room_full  = (n_q >= NMAX);
  assign shift_last_dn = (sidx_q == n_q);
  assign used_w     = ({{(SW-17){1'b0}}, bump_q} > sum_q) ?
                      17'({{(SW-17){1'b0}}, bump_q} - sum_q) : 17'd0;
  assign free_w     = (heap_top > used_w) ? heap_top - used_w : 17'd0;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            ffha_pkg::OP_ALLOC: state_d = zero_size ? ffha_pkg::S_DONE : ffha_pkg::S_RD;
            ffha_pkg::OP_FREE:  state_d = free_bad ? ffha_pkg::S_DONE : ffha_pkg::S_TAG;
            default:            state_d = ffha_pkg::S_DONE;
          endcase
        end
      end
      ffha_pkg::S_TAG: state_d = ffha_pkg::S_RD;
      ffha_pkg::S_RD: begin
        if (!scan_end) state_d = ffha_pkg::S_CHK;
        else state_d = is_alloc_q ? ffha_pkg::S_DONE : ffha_pkg::S_DEC;
      end
      ffha_pkg::S_CHK: begin
        if (is_alloc_q) begin
          if (!fit) state_d = ffha_pkg::S_RD;
          else if (!split && (idx_q + CW'(1) < n_q)) state_d = ffha_pkg::S_SH_RD;
          else state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = below ? ffha_pkg::S_RD : ffha_pkg::S_DEC;
        end
      end
      ffha_pkg::S_DEC: begin
        if (mnext && mprev) begin
          state_d = (idx_q + CW'(1) < n_q) ? ffha_pkg::S_SH_RD : ffha_pkg::S_DONE;
        end else if (mnext || mprev) begin
          state_d = ffha_pkg::S_DONE;
        end else if (room_full) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = (idx_q < n_q) ? ffha_pkg::S_SH_RD : ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_SH_RD: state_d = ffha_pkg::S_SH_WR;
      ffha_pkg::S_SH_WR: begin
        if (dir_up_q) state_d = (sidx_q == idx_q) ? ffha_pkg::S_FIN : ffha_pkg::S_SH_RD;
        else state_d = shift_last_dn ? ffha_pkg::S_DONE : ffha_pkg::S_SH_RD;
      end
      ffha_pkg::S_FIN:  state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: state_d = out_free ? ffha_pkg::S_IDLE : ffha_pkg::S_DONE;
      default:          state_d = ffha_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory and output-register controls.
  always_comb begin
    n_d = n_q;  idx_d = idx_q;  sidx_d = sidx_q;  bump_d = bump_q;
    live_d = live_q;  sum_d = sum_q;  is_alloc_d = is_alloc_q;  dir_up_d = dir_up_q;
    have_prev_d = have_prev_q;  have_cur_d = have_cur_q;  asize_d = asize_q;
    h_d = h_q;  size_d = size_q;  prev_d = prev_q;  cur_d = cur_q;
    status_d = status_q;  payload_d = payload_q;
    out_valid_d = out_valid_q && out_stall_i;
    ostat_d = ostat_q;  opay_d = opay_q;  olive_d = olive_q;
    oused_d = oused_q;  ofree_d = ofree_q;
    ft_we = 1'b0;  ft_re = 1'b0;  ft_waddr = idx_q[IW-1:0];
    ft_raddr = idx_q[IW-1:0];  ft_wdata = ft_rdata;
    tg_we = 1'b0;  tg_re = 1'b0;  tg_waddr = h_q[15:2];  tg_wdata = 16'd0;
    tg_raddr = h_in[15:2];
    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          status_d = ffha_pkg::STS_OK;
          payload_d = 16'd0;
          idx_d = '0;
          have_prev_d = 1'b0;
          have_cur_d = 1'b0;
          is_alloc_d = (opcode_i == ffha_pkg::OP_ALLOC);
          asize_d = asize_in;
          h_d = h_in;
          case (opcode_i)
            ffha_pkg::OP_ALLOC: if (zero_size) status_d = ffha_pkg::STS_ZERO_SIZE;
            ffha_pkg::OP_FREE: begin
              if (free_bad) status_d = ffha_pkg::STS_IGNORED;
              else tg_re = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ffha_pkg::S_TAG: size_d = tg_rdata;
      ffha_pkg::S_RD: begin
        if (!scan_end) begin
          ft_re = 1'b1;
        end else if (is_alloc_q) begin
          // No free block fits: take fresh space past the bump pointer.
          if (bump_fail) begin
            status_d = ffha_pkg::STS_NO_SPACE;
          end else begin
            tg_we = 1'b1;
            tg_waddr = next_bump[15:2];
            tg_wdata = asize_q[15:0];
            bump_d = bump_need[16:0];
            if (live_q != ffha_pkg::LIVE_MAX) live_d = live_q + 13'd1;
            payload_d = 16'(next_bump + HDR);
          end
        end
      end
      ffha_pkg::S_CHK: begin
        if (is_alloc_q) begin
          if (!fit) begin
            idx_d = idx_q + CW'(1);
          end else begin
            if (live_q != ffha_pkg::LIVE_MAX) live_d = live_q + 13'd1;
            payload_d = 16'({1'b0, ft_rdata.start} + HDR);
            tg_we = (ft_rdata.start[16] == 1'b0);
            tg_waddr = ft_rdata.start[15:2];
            if (split) begin
              // Keep the tail of the block as a smaller free entry.
              tg_wdata = asize_q[15:0];
              ft_we = 1'b1;
              ft_wdata.start = 17'({1'b0, ft_rdata.start} + HDR + asize_q);
              ft_wdata.len = 16'(rem - HDR);
              sum_d = sum_q - SW'(asize_q) - SW'(HDR);
            end else begin
              // Whole block used: delete the entry.
              tg_wdata = ft_rdata.len;
              n_d = n_q - CW'(1);
              sidx_d = idx_q + CW'(1);
              dir_up_d = 1'b0;
              sum_d = sum_q - SW'(ft_rdata.len) - SW'(HDR);
            end
          end
        end else if (below) begin
          prev_d = ft_rdata;
          have_prev_d = 1'b1;
          idx_d = idx_q + CW'(1);
        end else begin
          cur_d = ft_rdata;
          have_cur_d = 1'b1;
        end
      end
      ffha_pkg::S_DEC: begin
        if (live_q != 13'd0) live_d = live_q - 13'd1;
        if (mnext && mprev) begin
          // Block bridges both neighbours: grow the predecessor, drop the successor.
          ft_we = 1'b1;
          ft_waddr = IW'(idx_q - CW'(1));
          ft_wdata.start = prev_q.start;
          ft_wdata.len = newprev_both;
          n_d = n_q - CW'(1);
          sidx_d = idx_q + CW'(1);
          dir_up_d = 1'b0;
          sum_d = sum_q + SW'(newprev_both) - SW'(cur_q.len) - SW'(prev_q.len) - SW'(HDR);
        end else if (mnext) begin
          ft_we = 1'b1;
          ft_wdata.start = {1'b0, h_q};
          ft_wdata.len = merged;
          sum_d = sum_q + SW'(merged) - SW'(cur_q.len);
        end else if (mprev) begin
          ft_we = 1'b1;
          ft_waddr = IW'(idx_q - CW'(1));
          ft_wdata.start = prev_q.start;
          ft_wdata.len = newprev_only;
          sum_d = sum_q + SW'(newprev_only) - SW'(prev_q.len);
        end else if (room_full) begin
          status_d = ffha_pkg::STS_TABLE_FULL;
        end else begin
          // Open a slot at the insert position, moving entries up from the top.
          sidx_d = n_q - CW'(1);
          dir_up_d = 1'b1;
          sum_d = sum_q + SW'(size_q) + SW'(HDR);
        end
      end
      ffha_pkg::S_SH_RD: begin
        ft_re = 1'b1;
        ft_raddr = sidx_q[IW-1:0];
      end
      ffha_pkg::S_SH_WR: begin
        ft_we = 1'b1;
        ft_wdata = ft_rdata;
        if (dir_up_q) begin
          ft_waddr = IW'(sidx_q + CW'(1));
          sidx_d = sidx_q - CW'(1);
        end else begin
          ft_waddr = IW'(sidx_q - CW'(1));
          sidx_d = sidx_q + CW'(1);
        end
      end
      ffha_pkg::S_FIN: begin
        ft_we = 1'b1;
        ft_wdata.start = {1'b0, h_q};
        ft_wdata.len = size_q;
        n_d = n_q + CW'(1);
      end
      ffha_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ostat_d = status_q;
          opay_d = payload_q;
          olive_d = live_q;
          oused_d = used_w;
          ofree_d = free_w;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_IDLE;
      heap_size_q <= 17'h10000;
      n_q         <= '0;
      bump_q      <= '0;
      live_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      bump_q      <= bump_d;
      live_q      <= live_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) heap_size_q <= cfg_data_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  sidx_q <= sidx_d;  is_alloc_q <= is_alloc_d;
    dir_up_q <= dir_up_d;  have_prev_q <= have_prev_d;  have_cur_q <= have_cur_d;
    asize_q <= asize_d;  h_q <= h_d;  size_q <= size_d;
    prev_q <= prev_d;  cur_q <= cur_d;
    status_q <= status_d;  payload_q <= payload_d;
    ostat_q <= ostat_d;  opay_q <= opay_d;  olive_q <= olive_d;
    oused_q <= oused_d;  ofree_q <= ofree_d;
  end

  assign in_stall_o       = (state_q != ffha_pkg::S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign status_o         = ostat_q;
  assign payload_offset_o = opay_q;
  assign live_blocks_o    = olive_q;
  assign used_bytes_o     = oused_q;
  assign free_bytes_o     = ofree_q;

  // The free table never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NMAX)
    else $error("free table count overflow");

  // An entry is examined only below the current count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_CHK) |-> (idx_q < n_q))
    else $error("scan read beyond table fill");

  // The table is never written while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_IDLE) |-> !ft_we)
    else $error("free table written while idle");

  // The live count moves by at most one per item, and never while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_IDLE) |=> (live_q == $past(live_q)))
    else $error("live count changed at accept");

endmodule
